// ----- sv/irq_rate_top_k_monitor_top_assert.svh -----
`ifndef IRQ_RATE_TOP_K_MONITOR_TOP_ASSERT_SVH
`define IRQ_RATE_TOP_K_MONITOR_TOP_ASSERT_SVH

// same-cycle check: cons holds whenever ante holds
`define IRQ_RTK_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle check: cons holds in the cycle after ante
`define IRQ_RTK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/irq_rtk_pkg.sv -----
package irq_rtk_pkg;

  // default sizes
  localparam int MAX_IRQS_DEF = 1024;
  localparam int TOP_K_DEF    = 10;

  // fixed field widths
  localparam int OP_W   = 2;
  localparam int NUM_W  = 10;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 11;
  localparam int RANK_W = 4;

  localparam logic [CFG_W-1:0] IRQS_IN_USE_RST = 11'd1024;

  // result kinds
  localparam logic KIND_TOTAL = 1'b0;
  localparam logic KIND_RANK  = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_SAMPLE    = 2'd0,
    OP_SWEEP_END = 2'd1,
    OP_REPORT    = 2'd2,
    OP_IGNORE    = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SAMPLE_WR,
    ST_RANK_RD,
    ST_RANK_CMP,
    ST_EMIT
  } state_t;

  // sequencer to ranking unit
  typedef struct packed {
    logic clear;
    logic step;
  } rank_ctrl_t;

  // ranking unit to sequencer
  typedef struct packed {
    logic done;
    logic valid;
  } rank_stat_t;

  // count increase, zero when the count did not grow
  function automatic logic [CNT_W-1:0] rise_of(input logic [CNT_W-1:0] count,
                                               input logic [CNT_W-1:0] last);
    rise_of = (count <= last) ? '0 : count - last;
  endfunction

endpackage

// ----- sv/irq_rate_top_k_monitor_top.sv -----
// Sample word: a store read, then a read-modify-write; a skipped sample does not leave idle.
// End-of-sweep word: taken without leaving idle, its result strobes on the following cycle.
// Report word: per line in use a read, then comparator steps until the line is placed or
//   all TOP_K slots are passed, then a read-out of the TOP_K slots with each result registered; results never stall.
// Reset: synchronous; a clearing pass over all MAX_IRQS lines zeroes both count
//   stores while busy is high; cfg writes are taken at any time.
`include "irq_rate_top_k_monitor_top_assert.svh"

module irq_rate_top_k_monitor_top #(
  parameter int MAX_IRQS = irq_rtk_pkg::MAX_IRQS_DEF,
  parameter int TOP_K    = irq_rtk_pkg::TOP_K_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [irq_rtk_pkg::OP_W-1:0]   operation,
  input  logic [irq_rtk_pkg::NUM_W-1:0]  irq_number,
  input  logic [irq_rtk_pkg::CNT_W-1:0]  sample_count,
  input  logic                           has_handler,
  input  logic                           cfg_wr_en,
  input  logic [irq_rtk_pkg::CFG_W-1:0]  cfg_wr_data,
  output logic                           result_valid,
  output logic                           result_kind,
  output logic [irq_rtk_pkg::RANK_W-1:0] rank,
  output logic                           entry_valid,
  output logic [irq_rtk_pkg::NUM_W-1:0]  ranked_irq,
  output logic [irq_rtk_pkg::CNT_W-1:0]  ranked_delta,
  output logic [irq_rtk_pkg::CNT_W-1:0]  total_delta,
  output logic                           last_of_run
);
  import irq_rtk_pkg::*;

  localparam int LINE_W = $clog2(MAX_IRQS);
  localparam int POS_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam int LIM_W  = (CFG_W > LINE_W + 1) ? CFG_W : LINE_W + 1;
  localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(MAX_IRQS - 1);
  localparam logic [POS_W-1:0]  LAST_POS  = POS_W'(TOP_K - 1);

  state_t            state, state_next;
  logic [CFG_W-1:0]  irqs_in_use;
  logic [CNT_W-1:0]  running_sum;
  logic [CNT_W-1:0]  previous_total;
  logic [CNT_W-1:0]  latest_total;
  logic [LINE_W-1:0] clr_addr;
  logic [LINE_W-1:0] line_idx;
  logic [POS_W-1:0]  emit_idx;
  logic [LINE_W-1:0] s_line;
  logic [CNT_W-1:0]  s_count;

  logic              accept;
  op_t               op;
  logic [LIM_W-1:0]  n_lines;
  logic              sample_ok;
  logic              in_range;
  logic              last_line;

  logic              st_rd_en_unused;
  logic [LINE_W-1:0] rd_addr;
  logic [CNT_W-1:0]  rd_last;
  logic [CNT_W-1:0]  rd_delta;
  logic              wr_en;
  logic [LINE_W-1:0] wr_addr;
  logic [CNT_W-1:0]  wr_last;
  logic [CNT_W-1:0]  wr_delta;

  rank_ctrl_t        rank_ctrl;
  rank_stat_t        rank_stat;
  logic [LINE_W-1:0] slot_line;
  logic [CNT_W-1:0]  slot_delta;

  // handshake and decode
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign op        = op_t'(operation);
  assign n_lines   = (LIM_W'(irqs_in_use) > LIM_W'(MAX_IRQS)) ? LIM_W'(MAX_IRQS)
                                                              : LIM_W'(irqs_in_use);
  assign sample_ok = has_handler || (sample_count != '0);
  assign in_range  = LIM_W'(irq_number) < n_lines;
  assign last_line = (LIM_W'(line_idx) == (n_lines - 1'b1));
  assign st_rd_en_unused = 1'b0;

  // store port steering
  assign rd_addr  = (state == ST_IDLE) ? LINE_W'(irq_number) : line_idx;
  assign wr_en    = (state == ST_CLEAR) || (state == ST_SAMPLE_WR);
  assign wr_addr  = (state == ST_CLEAR) ? clr_addr : s_line;
  assign wr_last  = (state == ST_CLEAR) ? '0 : s_count;
  assign wr_delta = (state == ST_CLEAR) ? '0 : rise_of(s_count, rd_last);

  irq_rtk_store #(
    .MAX_IRQS (MAX_IRQS)
  ) u_store (
    .clk      (clk),
    .rd_addr  (rd_addr),
    .rd_last  (rd_last),
    .rd_delta (rd_delta),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_last  (wr_last),
    .wr_delta (wr_delta)
  );

  irq_rtk_rank #(
    .MAX_IRQS (MAX_IRQS),
    .TOP_K    (TOP_K)
  ) u_rank (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (rank_ctrl),
    .rd_idx     (emit_idx),
    .cand_line  (line_idx),
    .cand_delta (rd_delta),
    .stat       (rank_stat),
    .rd_line    (slot_line),
    .rd_delta   (slot_delta)
  );

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state and ranking control
  always_comb begin
    state_next      = state;
    rank_ctrl.clear = st_rd_en_unused;
    rank_ctrl.step  = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_LINE) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          unique case (op)
            OP_SAMPLE: begin
              if (sample_ok && in_range) state_next = ST_SAMPLE_WR;
            end
            OP_REPORT: begin
              rank_ctrl.clear = 1'b1;
              state_next      = (n_lines == '0) ? ST_EMIT : ST_RANK_RD;
            end
            OP_SWEEP_END: state_next = ST_IDLE;
            OP_IGNORE:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_SAMPLE_WR: state_next = ST_IDLE;
      ST_RANK_RD:   state_next = ST_RANK_CMP;
      ST_RANK_CMP: begin
        rank_ctrl.step = 1'b1;
        if (rank_stat.done) state_next = last_line ? ST_EMIT : ST_RANK_RD;
      end
      ST_EMIT: begin
        if (emit_idx == LAST_POS) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath registers and result word
  always_ff @(posedge clk) begin
    if (rst) begin
      irqs_in_use    <= IRQS_IN_USE_RST;
      running_sum    <= '0;
      previous_total <= '0;
      latest_total   <= '0;
      clr_addr       <= '0;
      line_idx       <= '0;
      emit_idx       <= '0;
      result_valid   <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      if (cfg_wr_en) irqs_in_use <= cfg_wr_data;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;

      if (accept) begin
        s_line  <= LINE_W'(irq_number);
        s_count <= sample_count;
        if (op == OP_SWEEP_END) begin
          latest_total   <= running_sum - previous_total;
          previous_total <= running_sum;
          running_sum    <= '0;
          result_valid   <= 1'b1;
          result_kind    <= KIND_TOTAL;
          rank           <= '0;
          entry_valid    <= 1'b0;
          ranked_irq     <= '0;
          ranked_delta   <= '0;
          total_delta    <= running_sum - previous_total;
          last_of_run    <= 1'b1;
        end
        if (op == OP_REPORT) begin
          line_idx <= '0;
          emit_idx <= '0;
        end
      end

      if (state == ST_SAMPLE_WR) running_sum <= running_sum + s_count;
      if ((state == ST_RANK_CMP) && rank_stat.done) line_idx <= line_idx + 1'b1;

      // ranking read-out, one slot per cycle
      if (state == ST_EMIT) begin
        result_valid <= 1'b1;
        result_kind  <= KIND_RANK;
        rank         <= RANK_W'(emit_idx);
        entry_valid  <= rank_stat.valid;
        ranked_irq   <= rank_stat.valid ? NUM_W'(slot_line) : '0;
        ranked_delta <= rank_stat.valid ? slot_delta : '0;
        total_delta  <= latest_total;
        last_of_run  <= (emit_idx == LAST_POS);
        emit_idx     <= emit_idx + 1'b1;
      end
    end
  end

  // checks
  `IRQ_RTK_HOLDS(a_no_result_in_clear, state == ST_CLEAR, !result_valid, "result during clear")
  `IRQ_RTK_HOLDS(a_total_single, result_valid && (result_kind == KIND_TOTAL), last_of_run && (rank == '0) && !entry_valid, "bad total word")
  `IRQ_RTK_NEXT(a_sweep_result, accept && (op == OP_SWEEP_END), result_valid && (result_kind == KIND_TOTAL), "missing total word")
  `IRQ_RTK_HOLDS(a_report_ends_idle, result_valid && (result_kind == KIND_RANK) && last_of_run, !busy, "busy after last rank")
  `IRQ_RTK_HOLDS(a_step_only_cmp, rank_stat.done, state == ST_RANK_CMP, "rank step outside compare")

endmodule

// ----- sv/irq_rtk_store.sv -----
module irq_rtk_store #(
  parameter int MAX_IRQS = 1024
) (
  input  logic                          clk,
  input  logic [$clog2(MAX_IRQS)-1:0]   rd_addr,
  output logic [irq_rtk_pkg::CNT_W-1:0] rd_last,
  output logic [irq_rtk_pkg::CNT_W-1:0] rd_delta,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_IRQS)-1:0]   wr_addr,
  input  logic [irq_rtk_pkg::CNT_W-1:0] wr_last,
  input  logic [irq_rtk_pkg::CNT_W-1:0] wr_delta
);
  import irq_rtk_pkg::*;

  logic [CNT_W-1:0] last_mem  [MAX_IRQS];
  logic [CNT_W-1:0] delta_mem [MAX_IRQS];

  // one write port, one registered read port per store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      last_mem[wr_addr]  <= wr_last;
      delta_mem[wr_addr] <= wr_delta;
    end
    rd_last  <= last_mem[rd_addr];
    rd_delta <= delta_mem[rd_addr];
  end

endmodule

// ----- sv/irq_rtk_rank.sv -----
module irq_rtk_rank #(
  parameter int MAX_IRQS = 1024,
  parameter int TOP_K    = 10
) (
  input  logic                                        clk,
  input  logic                                        rst,
  input  irq_rtk_pkg::rank_ctrl_t                     ctrl,
  input  logic [((TOP_K > 1) ? $clog2(TOP_K) : 1)-1:0] rd_idx,
  input  logic [$clog2(MAX_IRQS)-1:0]                 cand_line,
  input  logic [irq_rtk_pkg::CNT_W-1:0]               cand_delta,
  output irq_rtk_pkg::rank_stat_t                     stat,
  output logic [$clog2(MAX_IRQS)-1:0]                 rd_line,
  output logic [irq_rtk_pkg::CNT_W-1:0]               rd_delta
);
  import irq_rtk_pkg::*;

  localparam int LINE_W = $clog2(MAX_IRQS);
  localparam int POS_W  = (TOP_K > 1) ? $clog2(TOP_K) : 1;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(TOP_K - 1);

  logic [TOP_K-1:0]  slot_valid;
  logic [LINE_W-1:0] slot_line  [TOP_K];
  logic [CNT_W-1:0]  slot_delta [TOP_K];
  logic [POS_W-1:0]  pos;

  logic [POS_W-1:0]  sel_idx;
  logic              sel_valid;
  logic              greater;
  logic              place;

  // single read port: walk position while stepping, else read-out index
  assign sel_idx   = ctrl.step ? pos : rd_idx;
  assign sel_valid = slot_valid[sel_idx];
  assign rd_line   = slot_line[sel_idx];
  assign rd_delta  = slot_delta[sel_idx];

  // shared compare: strictly greater wins the slot
  assign greater = cand_delta > rd_delta;
  assign place   = !sel_valid || greater;

  assign stat.valid = sel_valid;
  assign stat.done  = ctrl.step && (place || (pos == LAST_POS));

  // insertion, one slot compared per cycle while stepping
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      pos        <= '0;
    end else if (ctrl.clear) begin
      slot_valid <= '0;
      pos        <= '0;
    end else if (ctrl.step) begin
      if (place) begin
        for (int k = 1; k < TOP_K; k++) begin
          if (POS_W'(k) > pos) begin
            slot_valid[k] <= slot_valid[k-1];
            slot_line[k]  <= slot_line[k-1];
            slot_delta[k] <= slot_delta[k-1];
          end
        end
        slot_valid[pos] <= 1'b1;
        slot_line[pos]  <= cand_line;
        slot_delta[pos] <= cand_delta;
        pos             <= '0;
      end else if (pos == LAST_POS) begin
        pos <= '0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import irq_rtk_pkg::*;

  localparam int LINES = MAX_IRQS_DEF;
  localparam int RANKS = TOP_K_DEF;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES = 40;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int REPORT_LIMIT = 10;

  // one result word as it leaves the block
  typedef struct packed {
    logic              kind;
    logic [RANK_W-1:0] pos;
    logic              filled;
    logic [NUM_W-1:0]  irq;
    logic [CNT_W-1:0]  rise;
    logic [CNT_W-1:0]  total;
    logic              last;
  } stat_word_t;

  typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_PAUSE} act_e;

  // one step of the stimulus: a command word, a register write or a pause
  typedef struct {
    act_e             kind;
    op_t              op;
    logic [NUM_W-1:0] num;
    logic [CNT_W-1:0] count;
    logic             handler;
    logic [CFG_W-1:0] cfg;
    int unsigned      gap;
  } plan_t;

  typedef enum logic [2:0] {
    DRV_FETCH, DRV_GAP, DRV_OFFER, DRV_DRAIN, DRV_SETTLE, DRV_HOLD
  } drv_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [OP_W-1:0] operation = '0;
  logic [NUM_W-1:0] irq_number = '0;
  logic [CNT_W-1:0] sample_count = '0;
  logic has_handler = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wr_data = '0;
  logic result_valid;
  logic result_kind;
  logic [RANK_W-1:0] rank;
  logic entry_valid;
  logic [NUM_W-1:0] ranked_irq;
  logic [CNT_W-1:0] ranked_delta;
  logic [CNT_W-1:0] total_delta;
  logic last_of_run;

  // stimulus and expected results
  plan_t sweep_plan[$];
  stat_word_t awaited_stats[$];
  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;

  // mirror of the monitor state
  bit [CNT_W-1:0] prev_count [LINES];
  bit [CNT_W-1:0] line_rise [LINES];
  bit [CNT_W-1:0] sweep_sum = '0;
  bit [CNT_W-1:0] sweep_base = '0;
  bit [CNT_W-1:0] last_sweep_rise = '0;
  bit [CFG_W-1:0] lines_cfg = IRQS_IN_USE_RST;

  // generator side bookkeeping
  bit [CNT_W-1:0] gen_last [LINES];
  int unsigned gen_cfg = LINES;
  bit burst = 1'b0;

  drv_e drv_state = DRV_FETCH;
  plan_t cur_word;
  int unsigned drv_wait = 0;

  irq_rate_top_k_monitor_top uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .irq_number   (irq_number),
    .sample_count (sample_count),
    .has_handler  (has_handler),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .result_valid (result_valid),
    .result_kind  (result_kind),
    .rank         (rank),
    .entry_valid  (entry_valid),
    .ranked_irq   (ranked_irq),
    .ranked_delta (ranked_delta),
    .total_delta  (total_delta),
    .last_of_run  (last_of_run)
  );

  // clock and reset
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // lines taking part in sweeps and ranking
  function automatic int unsigned lines_ranked();
    return (lines_cfg > LINES) ? LINES : lines_cfg;
  endfunction

  // apply one accepted word to the mirror and queue the words it yields
  task automatic track_irq_word(input plan_t w);
    stat_word_t r;
    bit slot_on [RANKS];
    bit [NUM_W-1:0] slot_irq [RANKS];
    int unsigned n;
    int ln;
    int p;
    int k;
    n = lines_ranked();
    case (w.op)
      OP_SAMPLE: begin
        if ((w.handler || w.count != 0) && w.num < n) begin
          line_rise[w.num] = (w.count <= prev_count[w.num]) ? '0 : w.count - prev_count[w.num];
          prev_count[w.num] = w.count;
          sweep_sum = sweep_sum + w.count;
        end
      end
      OP_SWEEP_END: begin
        last_sweep_rise = sweep_sum - sweep_base;
        sweep_base = sweep_sum;
        sweep_sum = '0;
        r = '0;
        r.kind = KIND_TOTAL;
        r.total = last_sweep_rise;
        r.last = 1'b1;
        awaited_stats.push_back(r);
      end
      OP_REPORT: begin
        for (p = 0; p < RANKS; p++) begin
          slot_on[p] = 1'b0;
          slot_irq[p] = '0;
        end
        // insertion ranking, ties keep the lower line ahead
        for (ln = 0; ln < n; ln++) begin
          for (p = 0; p < RANKS; p++) begin
            if (!slot_on[p]) begin
              slot_on[p] = 1'b1;
              slot_irq[p] = NUM_W'(ln);
              break;
            end
            if (line_rise[ln] > line_rise[slot_irq[p]]) begin
              for (k = RANKS - 1; k > p; k--) begin
                slot_on[k] = slot_on[k-1];
                slot_irq[k] = slot_irq[k-1];
              end
              slot_on[p] = 1'b1;
              slot_irq[p] = NUM_W'(ln);
              break;
            end
          end
        end
        for (p = 0; p < RANKS; p++) begin
          r.kind = KIND_RANK;
          r.pos = RANK_W'(p);
          r.filled = slot_on[p];
          r.irq = slot_on[p] ? slot_irq[p] : '0;
          r.rise = slot_on[p] ? line_rise[slot_irq[p]] : '0;
          r.total = last_sweep_rise;
          r.last = (p == RANKS - 1);
          awaited_stats.push_back(r);
        end
      end
      default: ;
    endcase
  endtask

  // stimulus building
  task automatic plan_word(input op_t op, input int unsigned num, input logic [CNT_W-1:0] count,
                           input logic handler);
    plan_t w;
    w.kind = ACT_WORD;
    w.op = op;
    w.num = num[NUM_W-1:0];
    w.count = count;
    w.handler = handler;
    w.cfg = '0;
    w.gap = burst ? 0 : $urandom_range(3, 0);
    sweep_plan.push_back(w);
  endtask

  task automatic plan_step(input act_e kind, input int unsigned value);
    plan_t w;
    w.kind = kind;
    w.op = OP_IGNORE;
    w.num = '0;
    w.count = '0;
    w.handler = 1'b0;
    w.cfg = value[CFG_W-1:0];
    w.gap = 0;
    sweep_plan.push_back(w);
    if (kind == ACT_CFG)
      gen_cfg = value;
  endtask

  // one sweep over the lines in use with noise mixed in
  task automatic plan_sweep(input bit with_report);
    int unsigned ln;
    int unsigned pick;
    logic [CNT_W-1:0] c;
    burst = ($urandom_range(2, 0) == 0);
    for (ln = 0; ln < gen_cfg; ln++) begin
      pick = $urandom_range(15, 0);
      if (pick == 0)
        plan_word(OP_IGNORE, $urandom_range(1023, 0), $urandom, 1'($urandom_range(1, 0)));
      if (pick == 1)
        plan_word(OP_SAMPLE, $urandom_range(1023, gen_cfg), $urandom, 1'b1);
      c = gen_last[ln] + $urandom_range(2000, 0);
      if (pick == 3)
        c = $urandom;
      if (pick == 4)
        c = gen_last[ln] - $urandom_range(50, 0);
      if (pick == 2) begin
        plan_word(OP_SAMPLE, ln, '0, 1'b0);
      end else if (pick != 5) begin
        gen_last[ln] = c;
        plan_word(OP_SAMPLE, ln, c, 1'($urandom_range(1, 0)));
      end
    end
    plan_word(OP_SWEEP_END, $urandom_range(1023, 0), $urandom, 1'($urandom_range(1, 0)));
    if (with_report)
      plan_word(OP_REPORT, $urandom_range(1023, 0), $urandom, 1'($urandom_range(1, 0)));
  endtask

  initial begin
    // directed: skip rule, count drops, ties, wrap of the sum
    plan_word(OP_SAMPLE, 0, 32'd0, 1'b0);
    plan_word(OP_SAMPLE, 0, 32'd0, 1'b1);
    plan_word(OP_SAMPLE, 1023, 32'hFFFF_FFFF, 1'b1);
    plan_word(OP_SAMPLE, 5, 32'd100, 1'b0);
    plan_word(OP_SAMPLE, 5, 32'd50, 1'b1);
    plan_word(OP_SAMPLE, 5, 32'd50, 1'b1);
    plan_word(OP_SAMPLE, 7, 32'd300, 1'b1);
    plan_word(OP_SAMPLE, 9, 32'd300, 1'b0);
    plan_word(OP_SAMPLE, 3, 32'd1, 1'b1);
    plan_word(OP_IGNORE, 1023, 32'hFFFF_FFFF, 1'b1);
    plan_word(OP_SWEEP_END, 1023, 32'hFFFF_FFFF, 1'b1);
    plan_word(OP_REPORT, 0, 32'd0, 1'b0);
    plan_word(OP_SAMPLE, 1023, 32'd5, 1'b1);
    plan_word(OP_SWEEP_END, 0, 32'd0, 1'b0);
    plan_word(OP_SWEEP_END, 512, 32'h8000_0000, 1'b0);
    plan_word(OP_REPORT, 1023, 32'hFFFF_FFFF, 1'b1);
    plan_step(ACT_PAUSE, 0);

    // no line in use
    plan_step(ACT_CFG, 0);
    plan_word(OP_REPORT, 0, 32'd0, 1'b0);
    plan_word(OP_SAMPLE, 0, 32'd9, 1'b1);
    plan_word(OP_SWEEP_END, 0, 32'd0, 1'b0);

    // a single line
    plan_step(ACT_CFG, 1);
    plan_word(OP_SAMPLE, 0, 32'd77, 1'b1);
    plan_word(OP_SAMPLE, 1, 32'd5, 1'b1);
    plan_word(OP_REPORT, 0, 32'd0, 1'b0);

    // in-use count above the store size
    plan_step(ACT_CFG, 2047);
    plan_word(OP_SAMPLE, 1023, 32'd123456, 1'b1);
    plan_word(OP_REPORT, 0, 32'd0, 1'b0);

    // random sweeps over small line sets
    plan_step(ACT_CFG, 12);
    repeat (3) plan_sweep($urandom_range(1, 0));
    plan_sweep(1'b1);
    plan_step(ACT_PAUSE, 0);
    plan_sweep(1'b1);
    plan_step(ACT_CFG, 18);
    plan_sweep($urandom_range(1, 0));
    plan_sweep(1'b1);
    plan_step(ACT_CFG, 1024);
  end

  // driver: one word at a time, random gaps, register writes when idle
  always @(posedge clk) begin : drive_words
    logic go;
    logic wr;
    go = start;
    wr = 1'b0;
    if (rst) begin
      go = 1'b0;
      drv_state = DRV_FETCH;
    end else begin
      case (drv_state)
        DRV_OFFER: if (!busy) begin
          // word taken at this edge
          track_irq_word(cur_word);
          go = 1'b0;
          drv_state = DRV_FETCH;
        end
        DRV_DRAIN: if (awaited_stats.size() == 0 && !busy) begin
          drv_wait = SETTLE_CYCLES;
          drv_state = DRV_SETTLE;
        end
        DRV_SETTLE: if (drv_wait != 0) begin
          drv_wait--;
        end else begin
          if (cur_word.kind == ACT_CFG) begin
            wr = 1'b1;
            cfg_wr_data <= cur_word.cfg;
            lines_cfg = cur_word.cfg;
          end
          drv_state = DRV_HOLD;
        end
        DRV_HOLD: drv_state = DRV_FETCH;
        default: ;
      endcase

      // next step from the plan
      if (drv_state == DRV_FETCH && sweep_plan.size() != 0) begin
        cur_word = sweep_plan.pop_front();
        drv_wait = cur_word.gap;
        drv_state = (cur_word.kind == ACT_WORD) ? DRV_GAP : DRV_DRAIN;
      end

      // idle gap, then present the word
      if (drv_state == DRV_GAP) begin
        if (drv_wait != 0) begin
          drv_wait--;
        end else begin
          operation <= cur_word.op;
          irq_number <= cur_word.num;
          sample_count <= cur_word.count;
          has_handler <= cur_word.handler;
          go = 1'b1;
          drv_state = DRV_OFFER;
        end
      end
    end
    start <= go;
    cfg_wr_en <= wr;
  end

  function automatic string fmt_stat(input stat_word_t s);
    return $sformatf("kind=%0d rank=%0d valid=%0d irq=%0d delta=%0h total=%0h last=%0d",
                     s.kind, s.pos, s.filled, s.irq, s.rise, s.total, s.last);
  endfunction

  // monitor: every strobed word against the oldest expectation
  always @(posedge clk) begin : check_results
    stat_word_t got;
    stat_word_t want;
    if (!rst && result_valid) begin
      got = {result_kind, rank, entry_valid, ranked_irq, ranked_delta, total_delta, last_of_run};
      if (awaited_stats.size() == 0) begin
        bad_count++;
        if (bad_count <= REPORT_LIMIT)
          $display("unexpected result word: %s", fmt_stat(got));
      end else begin
        want = awaited_stats.pop_front();
        if (got !== want) begin
          bad_count++;
          if (bad_count <= REPORT_LIMIT)
            $display("result word mismatch\n  expected %s\n  actual   %s",
                     fmt_stat(want), fmt_stat(got));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // end of run
  initial begin
    @(negedge rst);
    do @(posedge clk);
    while (!(drv_state == DRV_FETCH && sweep_plan.size() == 0 && awaited_stats.size() == 0
             && !busy && !start));
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_count == 0 && awaited_stats.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
